// ===== rtl/text_console_writer_core_defines.svh =====
// Assertion macros shared by the console writer checkers.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, with a disable condition.
`define TCW_ASSERT_SAME(label, clk, dis, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, with a disable condition.
`define TCW_ASSERT_NEXT(label, clk, dis, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

   // Screen store geometry
   localparam int MAX_CELLS   = 4096;
   localparam int CELL_AW     = $clog2(MAX_CELLS);
   localparam int CELL_W      = 16;
   // Cursor can run one row past the store end after a newline
   localparam int CURSOR_W    = CELL_AW + 1;

   // Configuration registers
   localparam int COLS_W      = 9;
   localparam int ROWS_W      = 7;
   localparam int CSR_DATA_W  = COLS_W;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS    = 1'b1;
   localparam logic [COLS_W-1:0] COLUMNS_RESET = 9'd80;
   localparam logic [ROWS_W-1:0] ROWS_RESET    = 7'd25;

   // Opcodes on the request channel
   localparam int OPCODE_W = 2;
   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

   // Characters
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] SPACE_CHAR   = 8'h20;

   // Command queue (depth is a power of two so pointers wrap)
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_NEWLINE,
      CMD_CLEAR,
      CMD_READ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [7:0]         char_code;
      logic [7:0]         attribute;
      logic [CELL_AW-1:0] cell_index;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_xfer_type;

endpackage

// ===== rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/tcw_front.sv =====
// Request front end: accepts items and classifies them into commands.
`timescale 1ns / 1ps
module tcw_front (
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tcw_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [7:0]                     req_char_code,
   input  logic [7:0]                     req_attribute,
   input  logic [tcw_pkg::CELL_AW-1:0]    req_cell_index,
   input  logic                           queue_full,
   output tcw_pkg::cmd_xfer_type          push
);
   import tcw_pkg::*;

   // Hold off the sender while the queue has no room
   assign req_stall = queue_full;

   // Decode opcode and character into a command
   always_comb begin
      push.valid          = req_valid & ~queue_full;
      push.cmd.char_code  = req_char_code;
      push.cmd.attribute  = req_attribute;
      push.cmd.cell_index = req_cell_index;
      unique case (req_opcode)
         OP_PUT: begin
            push.cmd.kind = (req_char_code == NEWLINE_CHAR) ? CMD_NEWLINE : CMD_PUT;
         end
         OP_CLEAR: push.cmd.kind = CMD_CLEAR;
         OP_READ:  push.cmd.kind = CMD_READ;
         OP_NONE:  push.cmd.kind = CMD_NOP;
      endcase
   end

endmodule

// ===== rtl/tcw_queue.sv =====
// Short command queue between the front end and the execution unit.
`timescale 1ns / 1ps
module tcw_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::cmd_xfer_type push,
   output logic                  full,
   output tcw_pkg::cmd_xfer_type head,
   input  logic                  pop
);
   import tcw_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ===== rtl/tcw_back.sv =====
// Execution unit: screen store, cursor, scroll, clear, newline and result register.
`timescale 1ns / 1ps
module tcw_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]   csr_data,
   input  tcw_pkg::cmd_xfer_type            head,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tcw_pkg::CURSOR_W-1:0]     rsp_cursor_cell,
   output logic [7:0]                       rsp_read_char,
   output logic [7:0]                       rsp_read_attribute,
   output logic                             rsp_scrolled
);
   import tcw_pkg::*;

   localparam int STEP_W = $clog2(CURSOR_W + 2);
   localparam int PROD_W = COLS_W + ROWS_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCROLL,
      ST_REMAIN,
      ST_WRITE,
      ST_CLEAR,
      ST_READ,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [COLS_W-1:0]   columns_ff, columns_in;
   logic [ROWS_W-1:0]   rows_ff, rows_in;
   logic [COLS_W-1:0]   eff_cols_ff, eff_cols_in;
   logic [CURSOR_W-1:0] scr_size_ff, scr_size_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [CURSOR_W-1:0] src_ff, src_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [CELL_AW-1:0]  wr_addr_ff, wr_addr_in;
   logic [CELL_AW-1:0]  clr_ff, clr_in;
   logic [CURSOR_W-1:0] div_ff, div_in;
   logic [COLS_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [7:0]          rc_ff, rc_in;
   logic [7:0]          ra_ff, ra_in;
   logic                scrolled_ff, scrolled_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic [7:0]          rsp_attr_ff, rsp_attr_in;
   logic                rsp_scrolled_ff, rsp_scrolled_in;

   logic                ram_we;
   logic [CELL_AW-1:0]  ram_waddr;
   logic [CELL_W-1:0]   ram_wdata;
   logic [CELL_AW-1:0]  ram_raddr;
   logic [CELL_W-1:0]   ram_rdata;

   logic [ROWS_W-1:0]   eff_rows;
   logic [PROD_W-1:0]   product;
   logic [CURSOR_W-1:0] cols_ext;
   logic [COLS_W:0]     trial;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (MAX_CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_cell    = rsp_cursor_ff;
   assign rsp_read_char      = rsp_char_ff;
   assign rsp_read_attribute = rsp_attr_ff;
   assign rsp_scrolled       = rsp_scrolled_ff;

   // Screen geometry: zero acts as one, size saturates at the store
   always_comb begin
      eff_cols_in = (columns_ff == '0) ? COLS_W'(1) : columns_ff;
      eff_rows    = (rows_ff == '0) ? ROWS_W'(1) : rows_ff;
      product     = PROD_W'(eff_cols_in) * PROD_W'(eff_rows);
      scr_size_in = (product > PROD_W'(MAX_CELLS)) ? CURSOR_W'(MAX_CELLS)
                                                   : CURSOR_W'(product);
      cols_ext    = CURSOR_W'(eff_cols_ff);
      trial       = {rem_ff, div_ff[CURSOR_W-1]};
   end

   // Command sequencer
   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      columns_in      = columns_ff;
      rows_in         = rows_ff;
      cursor_in       = cursor_ff;
      src_in          = src_ff;
      wr_pend_in      = wr_pend_ff;
      wr_addr_in      = wr_addr_ff;
      clr_in          = clr_ff;
      div_in          = div_ff;
      rem_in          = rem_ff;
      step_in         = step_ff;
      rc_in           = rc_ff;
      ra_in           = ra_ff;
      scrolled_in     = scrolled_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_attr_in     = rsp_attr_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      pop             = 1'b0;
      ram_we          = 1'b0;
      ram_waddr       = wr_addr_ff;
      ram_wdata       = ram_rdata;
      ram_raddr       = src_ff[CELL_AW-1:0];

      // Register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COLUMNS: columns_in = csr_data[COLS_W-1:0];
            CSR_ROWS:    rows_in    = csr_data[ROWS_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = head.cmd.cell_index;
            if (head.valid) begin
               pop         = 1'b1;
               cmd_in      = head.cmd;
               rc_in       = '0;
               ra_in       = '0;
               scrolled_in = 1'b0;
               step_in     = '0;
               unique case (head.cmd.kind)
                  CMD_PUT, CMD_NEWLINE: begin
                     if (cursor_ff >= scr_size_ff) begin
                        // Cursor past the end: scroll up one row first
                        scrolled_in = 1'b1;
                        src_in      = cols_ext;
                        wr_pend_in  = 1'b0;
                        cursor_in   = (cursor_ff >= cols_ext) ? cursor_ff - cols_ext : '0;
                        state_in    = ST_SCROLL;
                     end else if (head.cmd.kind == CMD_NEWLINE) begin
                        state_in = ST_REMAIN;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end
                  CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_READ: state_in = ST_READ;
                  CMD_NOP:  state_in = ST_DONE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end

         ST_SCROLL: begin
            // Read one cell a cycle, write it one row up the next cycle
            if (wr_pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (src_ff < scr_size_ff) begin
               ram_raddr  = src_ff[CELL_AW-1:0];
               wr_addr_in = CELL_AW'(src_ff - cols_ext);
               src_in     = src_ff + CURSOR_W'(1);
               wr_pend_in = 1'b1;
            end else begin
               wr_pend_in = 1'b0;
               if (!wr_pend_ff) begin
                  // Still beyond a shrunken screen: park on the last row
                  if (cursor_ff >= scr_size_ff) begin
                     cursor_in = (scr_size_ff > cols_ext) ? scr_size_ff - cols_ext : '0;
                  end
                  state_in = (cmd_ff.kind == CMD_NEWLINE) ? ST_REMAIN : ST_WRITE;
               end
            end
         end

         ST_REMAIN: begin
            // Restoring division, one quotient bit a cycle, for cursor mod columns
            priority if (step_ff == '0) begin
               div_in  = cursor_ff;
               rem_in  = '0;
               step_in = STEP_W'(1);
            end else if (step_ff <= STEP_W'(CURSOR_W)) begin
               rem_in  = (trial >= {1'b0, eff_cols_ff})
                         ? COLS_W'(trial - {1'b0, eff_cols_ff}) : COLS_W'(trial);
               div_in  = {div_ff[CURSOR_W-2:0], 1'b0};
               step_in = step_ff + STEP_W'(1);
            end else begin
               cursor_in = cursor_ff - CURSOR_W'(rem_ff) + cols_ext;
               state_in  = ST_DONE;
            end
         end

         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = cursor_ff[CELL_AW-1:0];
            ram_wdata = {cmd_ff.attribute, cmd_ff.char_code};
            cursor_in = cursor_ff + CURSOR_W'(1);
            state_in  = ST_DONE;
         end

         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = {cmd_ff.attribute, SPACE_CHAR};
            clr_in    = clr_ff + CELL_AW'(1);
            if (clr_ff == CELL_AW'(MAX_CELLS - 1)) begin
               state_in = ST_DONE;
            end
         end

         ST_READ: begin
            rc_in    = ram_rdata[7:0];
            ra_in    = ram_rdata[15:8];
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // Load the result register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_cursor_in   = cursor_ff;
               rsp_char_in     = rc_ff;
               rsp_attr_in     = ra_ff;
               rsp_scrolled_in = scrolled_ff;
               state_in        = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         columns_ff   <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
         cursor_ff    <= '0;
         wr_pend_ff   <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         cursor_ff    <= cursor_in;
         wr_pend_ff   <= wr_pend_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      eff_cols_ff     <= eff_cols_in;
      scr_size_ff     <= scr_size_in;
      cmd_ff          <= cmd_in;
      src_ff          <= src_in;
      wr_addr_ff      <= wr_addr_in;
      clr_ff          <= clr_in;
      div_ff          <= div_in;
      rem_ff          <= rem_in;
      rc_ff           <= rc_in;
      ra_ff           <= ra_in;
      scrolled_ff     <= scrolled_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_attr_ff     <= rsp_attr_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

endmodule

// ===== rtl/text_console_writer_core.sv =====
// Top level of the text console writer: front end, command queue and execution unit.
`timescale 1ns / 1ps
// Text-mode console writer. Keeps a 4096-cell screen store (character in bits 7..0,
// attribute in 15..8) and a cursor counted in cells; every request returns exactly one
// response with the cursor after the item. Requests pass a two-entry command queue, so
// the sender can run up to two items ahead while the store is busy. Work per item, set
// by the single-port-pair screen RAM and the sequencer: a plain character or a cell read
// passes one RAM access state before the response; a newline instead finds the cursor's
// column with a restoring divider that yields one bit a cycle; a put or newline that
// scrolls first copies the screen up one row, one cell a cycle through the RAM's read
// and write ports; a clear writes one cell a cycle over all 4096 cells of the store.
// The store has no reset: software clears it before reading. The user writes columns and
// rows through the csr port only while no item is in flight; the block does not check it.
module text_console_writer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tcw_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [7:0]                       req_char_code,
   input  logic [7:0]                       req_attribute,
   input  logic [tcw_pkg::CELL_AW-1:0]      req_cell_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tcw_pkg::CURSOR_W-1:0]     rsp_cursor_cell,
   output logic [7:0]                       rsp_read_char,
   output logic [7:0]                       rsp_read_attribute,
   output logic                             rsp_scrolled,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]   csr_data
);
   import tcw_pkg::*;

   cmd_xfer_type push;
   cmd_xfer_type head;
   logic         queue_full;
   logic         pop;

   // Register writes are always accepted
   assign csr_ready = 1'b1;

   tcw_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_attribute  (req_attribute),
      .req_cell_index (req_cell_index),
      .queue_full     (queue_full),
      .push           (push)
   );

   tcw_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   tcw_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cursor_cell    (rsp_cursor_cell),
      .rsp_read_char      (rsp_read_char),
      .rsp_read_attribute (rsp_read_attribute),
      .rsp_scrolled       (rsp_scrolled)
   );

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the top level.
`timescale 1ns / 1ps
`include "text_console_writer_core_defines.svh"
module tcw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [tcw_pkg::CURSOR_W-1:0] rsp_cursor_cell,
   input logic [7:0]                   rsp_read_char,
   input logic [7:0]                   rsp_read_attribute,
   input logic                         rsp_scrolled
);

   // Items transferred in but not yet answered (queue, unit and result register)
   logic [2:0] open_ff, open_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid & ~req_stall;
   assign rsp_xfer = rsp_valid & ~rsp_stall;

   always_comb begin
      open_in = open_ff;
      if (req_xfer && !rsp_xfer) begin
         open_in = open_ff + 3'd1;
      end else if (rsp_xfer && !req_xfer) begin
         open_in = open_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // A stalled response keeps its contents
   `TCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_cursor_cell) && $stable(rsp_read_char) && $stable(rsp_read_attribute) && $stable(rsp_scrolled), "response changed while stalled")

   // Reset empties the result register
   `TCW_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "response valid after reset")

   // No response without an item in flight
   `TCW_ASSERT_SAME(a_no_spurious, clock, reset, rsp_valid, open_ff != 3'd0, "response without a request")

   // An empty block never stalls the sender
   `TCW_ASSERT_SAME(a_empty_ready, clock, reset, open_ff == 3'd0, !req_stall, "stall with nothing in flight")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);
